// ===== rtl/core/s2l_pkg.sv =====
package s2l_pkg;

    localparam int FRAC_BITS = 16;

    localparam int RGB_W   = 8;
    localparam int LIN_W   = FRAC_BITS + 1;        // linear light, 0..1.0
    localparam int COEF_W  = FRAC_BITS;            // matrix coefficient
    localparam int PR_W    = LIN_W + COEF_W;       // one matrix product
    localparam int XYZ_W   = FRAC_BITS + 1;        // X, Y, Z up to ~1.09
    localparam int WHITE_W = 18;
    localparam int NUM_W   = FRAC_BITS + 17;       // ratio numerator and quotient
    localparam int ROOT_W  = FRAC_BITS + 6;        // cube root result
    localparam int SQ_W    = 2 * ROOT_W;
    localparam int P2_W    = SQ_W - FRAC_BITS;
    localparam int P3_W    = P2_W + ROOT_W;
    localparam int LT_W    = FRAC_BITS - 6;        // t on the linear segment
    localparam int LN_W    = FRAC_BITS + 10;       // linear segment numerator
    localparam int LF_W    = FRAC_BITS;            // linear segment result
    localparam int LIN_SH  = FRAC_BITS + 16;       // reciprocal shift
    localparam int RCP_W   = FRAC_BITS + 5;
    localparam int LP_W    = LN_W + RCP_W;
    localparam int F_W     = ROOT_W + 1;           // signed f and f differences
    localparam int PROD_W  = ROOT_W + 18;          // scaled L, a, b before rounding
    localparam int L_W     = 14;
    localparam int AB_W    = 15;
    localparam int ADDR_W  = 4;

    localparam longint unsigned SCALE   = 100000;
    localparam longint unsigned LIN_THR = (longint'(216) << FRAC_BITS) / 24389;
    localparam longint unsigned LIN_MUL = 24389;
    localparam longint unsigned LIN_K   = (longint'(432) << FRAC_BITS) + 1566;
    localparam longint unsigned LIN_DEN = 3132;
    localparam longint unsigned LIN_RCP = (longint'(1) << LIN_SH) / 3132;

    localparam longint L_MUL  = 11600;
    localparam longint L_OFF  = longint'(1600) << FRAC_BITS;
    localparam longint A_MUL  = 50000;
    localparam longint B_MUL  = 20000;
    localparam longint HALF   = longint'(1) << (FRAC_BITS - 1);
    localparam longint L_MAX  = 10000;
    localparam longint AB_MIN = -12800;
    localparam longint AB_MAX = 12799;

    localparam logic [1:0] REG_WHITE_X = 2'd0;
    localparam logic [1:0] REG_WHITE_Y = 2'd1;
    localparam logic [1:0] REG_WHITE_Z = 2'd2;

    localparam logic [WHITE_W-1:0] WHITE_X_RST = WHITE_W'(95047);
    localparam logic [WHITE_W-1:0] WHITE_Y_RST = WHITE_W'(100000);
    localparam logic [WHITE_W-1:0] WHITE_Z_RST = WHITE_W'(108883);

    typedef logic [255:0][LIN_W-1:0] lin_rom_t;
    typedef logic [8:0][COEF_W-1:0] coef_tab_t;

    // floor(a*b / 2^s)
    function automatic longint unsigned mul_floor(longint unsigned a, longint unsigned b,
                                                  int s);
        longint unsigned hi;
        longint unsigned lo;
        hi = a >> s;
        lo = a & ((longint'(1) << s) - 1);
        return hi * b + ((lo * b) >> s);
    endfunction

    function automatic longint unsigned lin_entry(int unsigned c);
        longint unsigned cc;
        longint unsigned x;
        longint unsigned u;
        longint unsigned r;
        longint unsigned cand;
        longint unsigned p2;
        longint unsigned p4;
        longint unsigned p5;
        longint unsigned v;
        cc = c;
        if (cc <= 10)
        begin
            return ((cc * 100 << FRAC_BITS) + 164730) / 329460;
        end
        x = (((cc * 1000 + 14025) << 30) + 134512) / 269025;
        u = mul_floor(x, x, 30);
        r = 0;
        for (int bit_i = 30; bit_i >= 0; bit_i--)
        begin
            cand = r | (longint'(1) << bit_i);
            p2 = mul_floor(cand, cand, 30);
            p4 = mul_floor(p2, p2, 30);
            p5 = mul_floor(p4, cand, 30);
            if (p5 <= u)
            begin
                r = cand;
            end
        end
        v = mul_floor(u, r, 30);
        return (v + (longint'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    endfunction

    function automatic lin_rom_t build_lin_rom();
        lin_rom_t rom;
        for (int c = 0; c < 256; c++)
        begin
            rom[c] = LIN_W'(lin_entry(c));
        end
        return rom;
    endfunction

    localparam lin_rom_t LIN_ROM = build_lin_rom();

    function automatic logic [COEF_W-1:0] coef_q(longint unsigned k);
        return COEF_W'(((k << FRAC_BITS) + 5000000) / 10000000);
    endfunction

    // row-major: index = row*3 + column, rows X Y Z, columns R G B
    function automatic coef_tab_t build_coef();
        coef_tab_t tab;
        tab[0] = coef_q(4124564);
        tab[1] = coef_q(3575761);
        tab[2] = coef_q(1804375);
        tab[3] = coef_q(2126729);
        tab[4] = coef_q(7151522);
        tab[5] = coef_q(721750);
        tab[6] = coef_q(193339);
        tab[7] = coef_q(1191920);
        tab[8] = coef_q(9503041);
        return tab;
    endfunction

    localparam coef_tab_t COEF = build_coef();

endpackage

// ===== rtl/core/srgb_to_cielab_unit.sv =====
// sRGB (D65 matrix) to CIELAB, L/a/b in hundredths, fixed point Q16 inside.
// Throughput: one pixel per clock unless the skid entry is full, set by a fully
// pipelined datapath (33-stage divider, 44-stage cube root, each per channel).
// A two-entry output (register plus skid) keeps s_tready registered.
// Reset (rst_n, async, low): pipeline and output emptied, white point back to D65.
module srgb_to_cielab_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        s_tlast,   // last_in

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // lightness [13:0], green_red [28:14],
                                   // blue_yellow [43:29], zero [47:44]
    output logic        m_tlast,   // last_out

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // pipeline stage map
    localparam int S_LIN  = 0;                              // gamma ROM
    localparam int S_PROD = 1;                              // matrix products
    localparam int S_XYZ  = 2;                              // row sums
    localparam int S_NUM  = 3;                              // ratio numerator
    localparam int S_DIV0 = 4;                              // divider stages
    localparam int S_CRV0 = S_DIV0 + s2l_pkg::NUM_W;        // curve entry
    localparam int S_DIFF = S_CRV0 + 2 * s2l_pkg::ROOT_W + 1;
    localparam int S_MUL  = S_DIFF + 1;
    localparam int S_OUT  = S_MUL + 1;
    localparam int NST    = S_OUT + 1;

    localparam int W  = s2l_pkg::WHITE_W;
    localparam int OD = 49;                                 // tlast + tdata

    // ---------------- configuration ----------------
    logic [W-1:0] white_x_reg;
    logic [W-1:0] white_y_reg;
    logic [W-1:0] white_z_reg;
    logic         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_x_reg <= s2l_pkg::WHITE_X_RST;
            white_y_reg <= s2l_pkg::WHITE_Y_RST;
            white_z_reg <= s2l_pkg::WHITE_Z_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                s2l_pkg::REG_WHITE_X: white_x_reg <= pwdata[W-1:0];
                s2l_pkg::REG_WHITE_Y: white_y_reg <= pwdata[W-1:0];
                s2l_pkg::REG_WHITE_Z: white_z_reg <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            s2l_pkg::REG_WHITE_X: prdata = 32'(white_x_reg);
            s2l_pkg::REG_WHITE_Y: prdata = 32'(white_y_reg);
            s2l_pkg::REG_WHITE_Z: prdata = 32'(white_z_reg);
            default:              prdata = '0;
        endcase
    end

    // white per channel; a zero white divides as one
    logic [W-1:0] white_w [0:2];
    logic [W-1:0] den_w   [0:2];

    always_comb
    begin
        white_w[0] = white_x_reg;
        white_w[1] = white_y_reg;
        white_w[2] = white_z_reg;
        for (int i = 0; i < 3; i++)
        begin
            den_w[i] = (white_w[i] == '0) ? W'(1) : white_w[i];
        end
    end

    // ---------------- pipeline control ----------------
    // all stages move together; only a full skid entry holds them
    logic           adv;
    logic           deliver;
    logic [NST-1:0] v_reg;
    logic [NST-1:0] last_reg;
    logic           out_v_reg;
    logic           skid_v_reg;

    assign adv      = !skid_v_reg;
    assign s_tready = adv;
    assign deliver  = adv && v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NST-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg <= {last_reg[NST-2:0], s_tlast};
        end
    end

    // ---------------- gamma and matrix ----------------
    logic [s2l_pkg::LIN_W-1:0] lin_reg  [0:2];
    logic [s2l_pkg::PR_W-1:0]  prod_reg [0:8];
    logic [s2l_pkg::XYZ_W-1:0] xyz_reg  [0:2];
    logic [s2l_pkg::NUM_W-1:0] num_reg  [0:2];
    logic [s2l_pkg::PR_W+1:0]  row_sum  [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            row_sum[i] = (s2l_pkg::PR_W+2)'(prod_reg[3*i])
                       + (s2l_pkg::PR_W+2)'(prod_reg[3*i+1])
                       + (s2l_pkg::PR_W+2)'(prod_reg[3*i+2])
                       + (s2l_pkg::PR_W+2)'(s2l_pkg::HALF);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lin_reg[0] <= s2l_pkg::LIN_ROM[s_tdata[7:0]];
            lin_reg[1] <= s2l_pkg::LIN_ROM[s_tdata[15:8]];
            lin_reg[2] <= s2l_pkg::LIN_ROM[s_tdata[23:16]];
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[3*i+j] <= s2l_pkg::PR_W'(lin_reg[j])
                                     * s2l_pkg::PR_W'(s2l_pkg::COEF[3*i+j]);
                end
                xyz_reg[i] <= s2l_pkg::XYZ_W'(row_sum[i] >> s2l_pkg::FRAC_BITS);
                // X*100000 + white/2: the rounding term of the ratio
                num_reg[i] <= s2l_pkg::NUM_W'(s2l_pkg::NUM_W'(xyz_reg[i])
                              * s2l_pkg::NUM_W'(s2l_pkg::SCALE))
                              + s2l_pkg::NUM_W'(white_w[i] >> 1);
            end
        end
    end

    // ---------------- ratio and Lab f, one lane per channel ----------------
    logic [s2l_pkg::NUM_W-1:0]  t_w [0:2];
    logic [s2l_pkg::ROOT_W-1:0] f_w [0:2];

    genvar ch;
    generate
        for (ch = 0; ch < 3; ch++)
        begin : g_chan
            s2l_divider u_div
            (
                .clk  (clk),
                .en   (adv),
                .num  (num_reg[ch]),
                .den  (den_w[ch]),
                .quot (t_w[ch])
            );

            s2l_lab_curve u_curve
            (
                .clk (clk),
                .en  (adv),
                .t   (t_w[ch]),
                .f   (f_w[ch])
            );
        end
    endgenerate

    // ---------------- L, a, b ----------------
    logic signed [s2l_pkg::F_W-1:0]    fy_reg;
    logic signed [s2l_pkg::F_W-1:0]    dxy_reg;
    logic signed [s2l_pkg::F_W-1:0]    dyz_reg;
    logic signed [s2l_pkg::PROD_W-1:0] lmul_reg;
    logic signed [s2l_pkg::PROD_W-1:0] amul_reg;
    logic signed [s2l_pkg::PROD_W-1:0] bmul_reg;
    logic signed [s2l_pkg::PROD_W-1:0] l_rnd;
    logic signed [s2l_pkg::PROD_W-1:0] a_rnd;
    logic signed [s2l_pkg::PROD_W-1:0] b_rnd;
    logic [s2l_pkg::L_W-1:0]           l_next;
    logic [s2l_pkg::AB_W-1:0]          a_next;
    logic [s2l_pkg::AB_W-1:0]          b_next;
    logic [s2l_pkg::L_W-1:0]           l_reg;
    logic [s2l_pkg::AB_W-1:0]          a_reg;
    logic [s2l_pkg::AB_W-1:0]          b_reg;

    // round half up = floor after adding half
    always_comb
    begin
        l_rnd = (lmul_reg + s2l_pkg::PROD_W'(s2l_pkg::HALF)) >>> s2l_pkg::FRAC_BITS;
        a_rnd = (amul_reg + s2l_pkg::PROD_W'(s2l_pkg::HALF)) >>> s2l_pkg::FRAC_BITS;
        b_rnd = (bmul_reg + s2l_pkg::PROD_W'(s2l_pkg::HALF)) >>> s2l_pkg::FRAC_BITS;

        priority if (l_rnd < 0)
            l_next = '0;
        else if (l_rnd > s2l_pkg::PROD_W'(s2l_pkg::L_MAX))
            l_next = s2l_pkg::L_W'(s2l_pkg::L_MAX);
        else
            l_next = s2l_pkg::L_W'(l_rnd);

        priority if (a_rnd < s2l_pkg::PROD_W'(s2l_pkg::AB_MIN))
            a_next = s2l_pkg::AB_W'(s2l_pkg::AB_MIN);
        else if (a_rnd > s2l_pkg::PROD_W'(s2l_pkg::AB_MAX))
            a_next = s2l_pkg::AB_W'(s2l_pkg::AB_MAX);
        else
            a_next = s2l_pkg::AB_W'(a_rnd);

        priority if (b_rnd < s2l_pkg::PROD_W'(s2l_pkg::AB_MIN))
            b_next = s2l_pkg::AB_W'(s2l_pkg::AB_MIN);
        else if (b_rnd > s2l_pkg::PROD_W'(s2l_pkg::AB_MAX))
            b_next = s2l_pkg::AB_W'(s2l_pkg::AB_MAX);
        else
            b_next = s2l_pkg::AB_W'(b_rnd);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fy_reg  <= $signed({1'b0, f_w[1]});
            dxy_reg <= $signed({1'b0, f_w[0]}) - $signed({1'b0, f_w[1]});
            dyz_reg <= $signed({1'b0, f_w[1]}) - $signed({1'b0, f_w[2]});

            lmul_reg <= s2l_pkg::PROD_W'(fy_reg) * s2l_pkg::PROD_W'(s2l_pkg::L_MUL)
                        - s2l_pkg::PROD_W'(s2l_pkg::L_OFF);
            amul_reg <= s2l_pkg::PROD_W'(dxy_reg) * s2l_pkg::PROD_W'(s2l_pkg::A_MUL);
            bmul_reg <= s2l_pkg::PROD_W'(dyz_reg) * s2l_pkg::PROD_W'(s2l_pkg::B_MUL);

            l_reg <= l_next;
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // ---------------- output register and skid ----------------
    logic [OD-1:0] pipe_data;
    logic [OD-1:0] out_data_reg;
    logic [OD-1:0] skid_data_reg;

    assign pipe_data = {last_reg[NST-1], 4'b0000, b_reg, a_reg, l_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || m_tready)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= deliver;
            end
        end
        else if (deliver)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || m_tready)
        begin
            out_data_reg <= skid_v_reg ? skid_data_reg : pipe_data;
        end
        else if (deliver)
        begin
            skid_data_reg <= pipe_data;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg[47:0];
    assign m_tlast  = out_data_reg[48];

`ifndef SYNTHESIS
    // skid only fills behind a held output
    assert property (@(posedge clk) disable iff (!rst_n) skid_v_reg |-> out_v_reg)
        else $error("skid entry without output entry");

    // input is held off only after the output was stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output stall");

    // an accepted request enters the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v_reg[S_LIN])
        else $error("accepted request lost at entry");

    // lightness clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13:0] <= 14'd10000))
        else $error("lightness out of range");
`endif

endmodule

// ===== rtl/core/s2l_divider.sv =====
// Restoring divider, one quotient bit per stage, MSB first.
module s2l_divider
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [s2l_pkg::NUM_W-1:0]   num,
    input  logic [s2l_pkg::WHITE_W-1:0] den,
    output logic [s2l_pkg::NUM_W-1:0]   quot
);

    logic [s2l_pkg::WHITE_W-1:0] rem_w [0:s2l_pkg::NUM_W-1];
    logic [s2l_pkg::NUM_W-1:0]   nq_w  [0:s2l_pkg::NUM_W];

    assign rem_w[0] = '0;
    assign nq_w[0]  = num;

    genvar j;
    generate
        for (j = 0; j < s2l_pkg::NUM_W; j++)
        begin : g_step
            logic [s2l_pkg::WHITE_W:0]   trial;
            logic [s2l_pkg::WHITE_W-1:0] rem_next;
            logic [s2l_pkg::NUM_W-1:0]   nq_next;
            logic [s2l_pkg::NUM_W-1:0]   nq_reg;

            always_comb
            begin
                trial = {rem_w[j], nq_w[j][s2l_pkg::NUM_W-1]};
                if (trial >= {1'b0, den})
                begin
                    rem_next = s2l_pkg::WHITE_W'(trial - {1'b0, den});
                    nq_next  = {nq_w[j][s2l_pkg::NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[s2l_pkg::WHITE_W-1:0];
                    nq_next  = {nq_w[j][s2l_pkg::NUM_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nq_reg <= nq_next;
                end
            end
            assign nq_w[j+1] = nq_reg;

            if (j < s2l_pkg::NUM_W - 1)
            begin : g_rem
                logic [s2l_pkg::WHITE_W-1:0] rem_reg;
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg <= rem_next;
                    end
                end
                assign rem_w[j+1] = rem_reg;
            end
        end
    endgenerate

    assign quot = nq_w[s2l_pkg::NUM_W];

endmodule

// ===== rtl/core/s2l_lab_curve.sv =====
// Lab f(t): bitwise cube root search, two stages per bit (square/cube, compare).
// Linear segment runs alongside through a reciprocal multiply.
module s2l_lab_curve
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [s2l_pkg::NUM_W-1:0]  t,
    output logic [s2l_pkg::ROOT_W-1:0] f
);

    localparam int RW = s2l_pkg::ROOT_W;
    localparam int FB = s2l_pkg::FRAC_BITS;

    logic [s2l_pkg::NUM_W-1:0] t0_reg;
    logic                      sel0_reg;
    logic [s2l_pkg::LN_W-1:0]  ln_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg   <= t;
            sel0_reg <= t > s2l_pkg::NUM_W'(s2l_pkg::LIN_THR);
            ln_reg   <= s2l_pkg::LN_W'(s2l_pkg::LN_W'(t[s2l_pkg::LT_W-1:0])
                        * s2l_pkg::LN_W'(s2l_pkg::LIN_MUL) + s2l_pkg::LN_W'(s2l_pkg::LIN_K));
        end
    end

    logic [RW-1:0]                 r_w   [0:RW];
    logic [s2l_pkg::SQ_W-1:0]      r2_w  [0:RW];
    logic [s2l_pkg::NUM_W-1:0]     t_w   [0:RW];
    logic                          sel_w [0:RW];

    assign r_w[0]   = '0;
    assign r2_w[0]  = '0;
    assign t_w[0]   = t0_reg;
    assign sel_w[0] = sel0_reg;

    genvar k;
    generate
        for (k = 0; k < RW; k++)
        begin : g_bit
            localparam int B = RW - 1 - k;

            logic [RW-1:0]            cand;
            logic [s2l_pkg::SQ_W-1:0] c2;
            logic [s2l_pkg::P2_W-1:0] p2;
            logic                     fit;

            logic [RW-1:0]             ra_reg;
            logic [s2l_pkg::SQ_W-1:0]  r2a_reg;
            logic [s2l_pkg::SQ_W-1:0]  c2_reg;
            logic [s2l_pkg::P3_W-1:0]  p3_reg;
            logic [s2l_pkg::NUM_W-1:0] ta_reg;
            logic                      sela_reg;

            logic [RW-1:0]             rb_reg;
            logic [s2l_pkg::SQ_W-1:0]  r2b_reg;
            logic [s2l_pkg::NUM_W-1:0] tb_reg;
            logic                      selb_reg;

            // (r + 2^B)^2 from the carried r^2; bits of r below B+1 are zero
            always_comb
            begin
                cand = r_w[k] | (RW'(1) << B);
                c2   = r2_w[k] + (s2l_pkg::SQ_W'(r_w[k]) << (B + 1))
                       + (s2l_pkg::SQ_W'(1) << (2 * B));
                p2   = c2[s2l_pkg::SQ_W-1:FB];
                fit  = (p3_reg >> FB) <= s2l_pkg::P3_W'(ta_reg);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ra_reg   <= r_w[k];
                    r2a_reg  <= r2_w[k];
                    c2_reg   <= c2;
                    p3_reg   <= s2l_pkg::P3_W'(p2) * s2l_pkg::P3_W'(cand);
                    ta_reg   <= t_w[k];
                    sela_reg <= sel_w[k];

                    rb_reg   <= fit ? (ra_reg | (RW'(1) << B)) : ra_reg;
                    r2b_reg  <= fit ? c2_reg : r2a_reg;
                    tb_reg   <= ta_reg;
                    selb_reg <= sela_reg;
                end
            end

            assign r_w[k+1]   = rb_reg;
            assign r2_w[k+1]  = r2b_reg;
            assign t_w[k+1]   = tb_reg;
            assign sel_w[k+1] = selb_reg;
        end
    endgenerate

    // linear segment: n / 3132 through reciprocal, one correction step
    logic [s2l_pkg::LP_W-1:0] lp_reg;
    logic [s2l_pkg::LN_W-1:0] ln1_reg;
    logic [s2l_pkg::LF_W-1:0] q0;
    logic [s2l_pkg::LN_W-1:0] lrem;
    logic [s2l_pkg::LF_W-1:0] lf_next;
    logic [s2l_pkg::LF_W-1:0] lf_reg [1:2*RW-1];

    always_comb
    begin
        q0   = s2l_pkg::LF_W'(lp_reg >> s2l_pkg::LIN_SH);
        lrem = ln1_reg - s2l_pkg::LN_W'(s2l_pkg::LN_W'(q0) * s2l_pkg::LN_W'(s2l_pkg::LIN_DEN));
        lf_next = (lrem >= s2l_pkg::LN_W'(s2l_pkg::LIN_DEN)) ? q0 + s2l_pkg::LF_W'(1) : q0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lp_reg    <= s2l_pkg::LP_W'(ln_reg) * s2l_pkg::LP_W'(s2l_pkg::LIN_RCP);
            ln1_reg   <= ln_reg;
            lf_reg[1] <= lf_next;
            for (int s = 2; s < 2 * RW; s++)
            begin
                lf_reg[s] <= lf_reg[s-1];
            end
        end
    end

    assign f = sel_w[RW] ? r_w[RW] : RW'(lf_reg[2*RW-1]);

endmodule
